/* sv/qai_pkg.sv */
// ============================================================================
// qai_pkg
// Shared types and constants of the quaternion attitude integrate unit.
// ============================================================================
package qai_pkg;

    // Four Q2.30 components, index 0 is w, then x, y, z
    typedef logic [3:0][31:0] t_quat;
    // Three Q8.24 rate components, x, y, z
    typedef logic [2:0][31:0] t_rate;

    // Beat passed from front to back: saturated sum and its squared length
    typedef struct packed {
        t_quat       s;
        logic [63:0] sum_sq;
    } t_item;

    localparam logic [31:0] TIME_STEP_RST = 32'd4294967;

    // Pipeline depths
    localparam int F_STAGES = 10;
    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 31;
    localparam int B_STAGES = 1 + SQ_STEPS + 1 + DV_STEPS + 1;

    // Hand-off queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Hamilton product (0, r) x q: term j of component c is
    // rate[j] * quat[QSEL[c][j]], negated where QNEG[c][j] is set
    localparam logic [1:0] QSEL [4][3] = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0}
    };
    localparam logic QNEG [4][3] = '{
        '{1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0}
    };

endpackage

/* sv/qai_front.sv */
// ============================================================================
// qai_front
// Product, increment, saturated sum and squared length, ten stages.
// ============================================================================
module qai_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  qai_pkg::t_quat       i_quat,
    input  qai_pkg::t_rate       i_rate,
    input  logic [31:0]          i_time_step,
    output logic                 o_wr,
    output qai_pkg::t_item       o_item,
    input  logic                 i_q_full
);

    logic [qai_pkg::F_STAGES-1:0] r_vld;
    logic adv;
    logic accept;

    logic signed [63:0] r_prod [4][3];
    logic signed [61:0] r_u    [4][3];
    logic signed [62:0] r_d    [4];
    logic        [61:0] r_m    [4];
    logic        [61:0] r_a    [4];
    logic        [63:0] r_b    [4];
    logic        [3:0]  r_neg4;
    logic        [3:0]  r_neg5;
    logic signed [40:0] r_inc  [4];
    logic        [62:0] r_sq   [4];
    logic        [63:0] r_p    [2];
    qai_pkg::t_quat     r_q1, r_q2, r_q3, r_q4, r_q5, r_q6;
    qai_pkg::t_quat     r_s7, r_s8, r_s9;
    qai_pkg::t_item     r_item;

    logic signed [61:0] n_u   [4][3];
    logic signed [62:0] n_d   [4];
    logic        [61:0] n_m   [4];
    logic signed [40:0] n_inc [4];
    qai_pkg::t_quat     n_s;
    logic        [62:0] n_sq  [4];
    logic        [63:0] n_sum;

    // stall only when the last stage holds a beat the queue cannot take
    assign adv    = !r_vld[qai_pkg::F_STAGES-1] || !i_q_full;
    assign o_full = !adv;
    assign accept = i_push && adv;
    assign o_wr   = r_vld[qai_pkg::F_STAGES-1] && !i_q_full;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[qai_pkg::F_STAGES-2:0], accept};
        end
    end

    // divide by four toward zero, then signed sum of the three terms
    always_comb begin
        logic signed [63:0] tb;
        logic signed [62:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                tb = r_prod[c][j] + (r_prod[c][j][63] ? 64'sd3 : 64'sd0);
                n_u[c][j] = tb[63:2];
                if (qai_pkg::QNEG[c][j]) begin
                    acc = acc - r_u[c][j];
                end else begin
                    acc = acc + r_u[c][j];
                end
            end
            n_d[c] = acc;
        end
    end

    // magnitude, rounded increment, saturated sum, squares
    always_comb begin
        logic signed [62:0] nd;
        logic        [62:0] cc;
        logic        [62:0] rnd;
        logic signed [40:0] rr;
        logic signed [41:0] ss;
        logic signed [63:0] pp;
        for (int c = 0; c < 4; c++) begin
            nd     = -r_d[c];
            n_m[c] = r_d[c][62] ? nd[61:0] : r_d[c][61:0];
            cc     = {1'b0, r_a[c]} + {31'd0, r_b[c][63:32]};
            rnd    = cc + 63'd4194304;
            rr     = {1'b0, rnd[62:23]};
            n_inc[c] = r_neg5[c] ? -rr : rr;
            ss     = {{10{r_q6[c][31]}}, r_q6[c]} + {r_inc[c][40], r_inc[c]};
            if (ss[41:31] != {11{ss[41]}}) begin
                n_s[c] = ss[41] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                n_s[c] = ss[31:0];
            end
            pp       = $signed(r_s7[c]) * $signed(r_s7[c]);
            n_sq[c]  = pp[62:0];
        end
    end

    // total of the two pair sums, clamped at 64 bits
    always_comb begin
        logic [64:0] tt;
        tt    = {1'b0, r_p[0]} + {1'b0, r_p[1]};
        n_sum = tt[64] ? '1 : tt[63:0];
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[c][j] <= $signed(i_rate[j]) *
                                    $signed(i_quat[qai_pkg::QSEL[c][j]]);
                    r_u[c][j]    <= n_u[c][j];
                end
                r_d[c]   <= n_d[c];
                r_m[c]   <= n_m[c];
                r_a[c]   <= r_m[c][61:32] * i_time_step;
                r_b[c]   <= r_m[c][31:0] * i_time_step;
                r_inc[c] <= n_inc[c];
                r_sq[c]  <= n_sq[c];
                r_neg4[c] <= r_d[c][62];
            end
            r_neg5 <= r_neg4;
            r_q1 <= i_quat;
            r_q2 <= r_q1;
            r_q3 <= r_q2;
            r_q4 <= r_q3;
            r_q5 <= r_q4;
            r_q6 <= r_q5;
            r_s7 <= n_s;
            r_s8 <= r_s7;
            r_s9 <= r_s8;
            r_p[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_p[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_item.s      <= r_s9;
            r_item.sum_sq <= n_sum;
        end
    end

endmodule

/* sv/qai_fifo.sv */
// ============================================================================
// qai_fifo
// Short flop queue between the front and back pipelines.
// ============================================================================
module qai_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  qai_pkg::t_item   i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output qai_pkg::t_item   o_rdata,
    output logic             o_empty
);

    qai_pkg::t_item          r_mem [qai_pkg::Q_DEPTH];
    logic [qai_pkg::Q_AW-1:0] r_wptr;
    logic [qai_pkg::Q_AW-1:0] r_rptr;
    logic [qai_pkg::Q_AW:0]   r_cnt;
    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == (qai_pkg::Q_AW+1)'(qai_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

/* sv/qai_back.sv */
// ============================================================================
// qai_back
// Length by a bit-pair square root pipe, then rounded division per lane.
// ============================================================================
module qai_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  qai_pkg::t_item   i_item,
    output logic             o_q_rd,
    output logic             o_empty,
    input  logic             i_pop,
    output qai_pkg::t_quat   o_next,
    output logic             o_degenerate
);

    localparam int SQ = qai_pkg::SQ_STEPS;
    localparam int DV = qai_pkg::DV_STEPS;
    localparam int BS = qai_pkg::B_STAGES;

    logic [BS-1:0] r_bv;
    logic adv;

    // square root pipe state
    logic [63:0]    r_n   [SQ+1];
    logic [63:0]    r_res [SQ+1];
    qai_pkg::t_quat r_bs  [SQ+1];

    // division pipe state
    logic [31:0] r_rem [DV+1][4];
    logic [30:0] r_low [DV+1][4];
    logic [31:0] r_r   [DV+1];
    logic [3:0]  r_neg [DV+1];
    logic        r_deg [DV+1];

    qai_pkg::t_quat r_out;
    logic           r_out_deg;

    // the output register is the last stage; the pipe moves when it frees
    assign adv          = !r_bv[BS-1] || i_pop;
    assign o_q_rd       = adv && !i_q_empty;
    assign o_empty      = !r_bv[BS-1];
    assign o_next       = r_out;
    assign o_degenerate = r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[BS-2:0], !i_q_empty};
        end
    end

    // load from the queue
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n[0]   <= i_item.sum_sq;
            r_res[0] <= '0;
            r_bs[0]  <= i_item.s;
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
        logic [64:0] trial;
        logic        ge;
        assign trial = {1'b0, r_res[k]} + {1'b0, BIT};
        assign ge    = ({1'b0, r_n[k]} >= trial);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_n[k+1]   <= ge ? r_n[k] - trial[63:0] : r_n[k];
                r_res[k+1] <= ge ? (r_res[k] >> 1) + BIT : r_res[k] >> 1;
                r_bs[k+1]  <= r_bs[k];
            end
        end
    end

    // set up dividend (m << 30) + r/2 per lane
    always_ff @(posedge i_clk) begin
        logic [31:0] r;
        logic [31:0] m;
        logic [31:0] ng;
        logic [61:0] num;
        if (adv) begin
            r = r_res[SQ][31:0];
            for (int c = 0; c < 4; c++) begin
                ng  = -r_bs[SQ][c];
                m   = r_bs[SQ][c][31] ? ng : r_bs[SQ][c];
                num = {m[31:0], 30'd0} + {31'd0, r[31:1]};
                r_rem[0][c] <= {1'b0, num[61:31]};
                r_low[0][c] <= num[30:0];
                r_neg[0][c] <= r_bs[SQ][c][31];
            end
            r_r[0]   <= r;
            r_deg[0] <= (r == '0);
        end
    end

    // restoring division, one quotient bit per stage and lane
    for (genvar k = 0; k < DV; k++) begin : g_div
        for (genvar c = 0; c < 4; c++) begin : g_lane
            logic [32:0] t;
            logic [32:0] d;
            logic        ge;
            assign t  = {r_rem[k][c], r_low[k][c][30]};
            assign ge = (t >= {1'b0, r_r[k]});
            assign d  = t - {1'b0, r_r[k]};
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rem[k+1][c] <= ge ? d[31:0] : t[31:0];
                    r_low[k+1][c] <= {r_low[k][c][29:0], ge};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_r[k+1]   <= r_r[k];
                r_neg[k+1] <= r_neg[k];
                r_deg[k+1] <= r_deg[k];
            end
        end
    end

    // sign and degenerate select into the output register
    always_ff @(posedge i_clk) begin
        logic [31:0] q;
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                q = {1'b0, r_low[DV][c]};
                if (r_deg[DV]) begin
                    r_out[c] <= '0;
                end else begin
                    r_out[c] <= r_neg[DV][c] ? -q : q;
                end
            end
            r_out_deg <= r_deg[DV];
        end
    end

endmodule

/* sv/quaternion_attitude_integrate_unit.sv */
// ============================================================================
// quaternion_attitude_integrate_unit
// First-order quaternion integration under body rate, then normalization.
// ============================================================================
// Throughput: one beat per cycle while the result side pops and full stays
// low; 10 front stages, a 4-entry queue, and a back pipe of 32 square root
// and 31 division stages.
// Reset (synchronous, active low) empties all stages and the queue and sets
// time_step to 4294967 (about 1 ms).
// ============================================================================
module quaternion_attitude_integrate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_quat_w,
    input  logic [31:0] i_quat_x,
    input  logic [31:0] i_quat_y,
    input  logic [31:0] i_quat_z,
    input  logic [31:0] i_rate_x,
    input  logic [31:0] i_rate_y,
    input  logic [31:0] i_rate_z,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_next_w,
    output logic [31:0] o_next_x,
    output logic [31:0] o_next_y,
    output logic [31:0] o_next_z,
    output logic        o_degenerate
);

    logic [31:0]    r_time_step;
    qai_pkg::t_quat quat;
    qai_pkg::t_rate rate;
    qai_pkg::t_item f_item;
    qai_pkg::t_item q_item;
    qai_pkg::t_quat next;
    logic f_wr;
    logic q_full;
    logic q_rd;
    logic q_empty;

    assign quat = {i_quat_z, i_quat_y, i_quat_x, i_quat_w};
    assign rate = {i_rate_z, i_rate_y, i_rate_x};

    // time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= qai_pkg::TIME_STEP_RST;
        end else if (i_cfg_wr_en) begin
            r_time_step <= i_cfg_wr_data;
        end
    end

    qai_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_quat      (quat),
        .i_rate      (rate),
        .i_time_step (r_time_step),
        .o_wr        (f_wr),
        .o_item      (f_item),
        .i_q_full    (q_full)
    );

    qai_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_wdata (f_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_item),
        .o_empty (q_empty)
    );

    qai_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_item       (q_item),
        .o_q_rd       (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_next       (next),
        .o_degenerate (o_degenerate)
    );

    assign o_next_w = next[0];
    assign o_next_x = next[1];
    assign o_next_y = next[2];
    assign o_next_z = next[3];

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the quaternion attitude integrate unit against a bit-exact predictor
// of the rate product, the saturated sum and the normalization. Beats go in
// under several time steps and idle patterns; results are compared in order.
// ============================================================================
module testbench;

    typedef struct {
        logic [31:0] q [4];
        logic [31:0] w [3];
    } t_attitude_in;

    typedef struct {
        logic [31:0] q [4];
        logic        degen;
    } t_attitude_out;

    // Bit-exact attitude update predictor and queue of pending updates
    class t_attitude_board;
        logic [31:0]   step_size;
        t_attitude_out pending [$];
        int            errors;

        function new();
            step_size = qai_pkg::TIME_STEP_RST;
            errors    = 0;
        endfunction

        // Scaled increment of one component from its three rate terms
        function logic signed [63:0] scaled_inc(logic signed [63:0] t0, t1, t2);
            logic signed [63:0] d;
            logic [63:0] m, hi, lo, a, b, c, r;
            logic neg;
            d   = t0 / 4 + t1 / 4 + t2 / 4;
            neg = d < 0;
            m   = neg ? -d : d;
            hi  = m >> 32;
            lo  = {32'd0, m[31:0]};
            a   = hi * {32'd0, step_size};
            b   = lo * {32'd0, step_size};
            c   = a + (b >> 32);
            r   = (c + (64'd1 << 22)) >> 23;
            return neg ? -$signed(r) : $signed(r);
        endfunction

        function logic signed [63:0] clip32(logic signed [63:0] v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [63:0] root64(logic [63:0] n);
            logic [63:0] res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Accepted input beat: predict its update
        function void note_input(t_attitude_in x);
            logic signed [63:0] qv [4];
            logic signed [63:0] wv [3];
            logic signed [63:0] s [4];
            logic [64:0] sumsq;
            logic [63:0] r, m, qq;
            t_attitude_out e;
            for (int i = 0; i < 4; i++) qv[i] = $signed(x.q[i]);
            for (int i = 0; i < 3; i++) wv[i] = $signed(x.w[i]);
            s[0] = clip32(qv[0] + scaled_inc(-(wv[0] * qv[1]), -(wv[1] * qv[2]),
                                              -(wv[2] * qv[3])));
            s[1] = clip32(qv[1] + scaled_inc(wv[0] * qv[0], wv[1] * qv[3],
                                              -(wv[2] * qv[2])));
            s[2] = clip32(qv[2] + scaled_inc(-(wv[0] * qv[3]), wv[1] * qv[0],
                                              wv[2] * qv[1]));
            s[3] = clip32(qv[3] + scaled_inc(wv[0] * qv[2], -(wv[1] * qv[1]),
                                              wv[2] * qv[0]));
            sumsq = 0;
            for (int i = 0; i < 4; i++) sumsq = sumsq + {1'b0, 64'(s[i] * s[i])};
            if (sumsq[64]) sumsq = {1'b0, {64{1'b1}}};
            r = root64(sumsq[63:0]);
            e.degen = (r == 0);
            for (int i = 0; i < 4; i++) begin
                if (r == 0) begin
                    e.q[i] = s[i][31:0];
                end else begin
                    m      = (s[i] < 0) ? -s[i] : s[i];
                    qq     = ((m << 30) + r / 2) / r;
                    e.q[i] = (s[i] < 0) ? 32'(-qq) : qq[31:0];
                end
            end
            pending.push_back(e);
        endfunction

        // Accepted result beat: compare with the oldest prediction
        function void check_result(t_attitude_out y);
            t_attitude_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 4; i++)
                if (e.q[i] !== y.q[i]) begin
                    $display("%0t: component %0d expected %h actual %h",
                             $time, i, e.q[i], y.q[i]);
                    errors++;
                end
            if (e.degen !== y.degen) begin
                $display("%0t: degenerate expected %b actual %b",
                         $time, e.degen, y.degen);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic [31:0] i_rate_x, i_rate_y, i_rate_z;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    logic        empty;
    logic        pop;
    logic [31:0] o_next_w, o_next_x, o_next_y, o_next_z;
    logic        o_degenerate;

    t_attitude_board board;
    int              send_idle_pct;
    int              pop_stall_pct;
    int              cycle_count;

    quaternion_attitude_integrate_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_quat_w      (i_quat_w),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .empty         (empty),
        .pop           (pop),
        .o_next_w      (o_next_w),
        .o_next_x      (o_next_x),
        .o_next_y      (o_next_y),
        .o_next_z      (o_next_z),
        .o_degenerate  (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: random stall at falling edge, sample at rising edge
    always @(negedge i_clk)
        if (i_rst_n) pop <= ($urandom_range(99) >= pop_stall_pct);

    always @(posedge i_clk) begin
        t_attitude_out y;
        if (i_rst_n && pop && !empty) begin
            y.q[0] = o_next_w;
            y.q[1] = o_next_x;
            y.q[2] = o_next_y;
            y.q[3] = o_next_z;
            y.degen = o_degenerate;
            board.check_result(y);
        end
    end

    // One input beat, with an optional random gap before it
    task automatic send_beat(t_attitude_in x);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                push = 1'b0;
                @(negedge i_clk);
            end
        end
        push     = 1'b1;
        i_quat_w = x.q[0];
        i_quat_x = x.q[1];
        i_quat_y = x.q[2];
        i_quat_z = x.q[3];
        i_rate_x = x.w[0];
        i_rate_y = x.w[1];
        i_rate_z = x.w[2];
        do @(posedge i_clk); while (full);
        board.note_input(x);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_step(logic [31:0] v);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en    = 1'b0;
        board.step_size = v;
    endtask

    function automatic t_attitude_in make_beat(logic [31:0] qw, qx, qy, qz,
                                               logic [31:0] wx, wy, wz);
        t_attitude_in x;
        x.q = '{qw, qx, qy, qz};
        x.w = '{wx, wy, wz};
        return x;
    endfunction

    // Mostly scaled-down attitudes and rates, some raw bit patterns
    function automatic t_attitude_in random_beat();
        t_attitude_in x;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 4; i++)
            x.q[i] = (mode < 3) ? $signed($urandom()) :
                                  $signed($urandom()) >>> $urandom_range(1, 4);
        for (int i = 0; i < 3; i++)
            x.w[i] = (mode < 3) ? $signed($urandom()) :
                                  $signed($urandom()) >>> $urandom_range(0, 24);
        return x;
    endfunction

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h4000_0000;

    initial begin
        logic [31:0] steps [5];
        int idle_s [5];
        int idle_p [5];
        board         = new();
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        {i_quat_w, i_quat_x, i_quat_y, i_quat_z} = '0;
        {i_rate_x, i_rate_y, i_rate_z} = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats at the reset time step, then at the largest and a zero time step
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));             // degenerate
        send_beat(make_beat(ONE, 0, 0, 0, 0, 0, 0));           // identity
        send_beat(make_beat(MINN, MINN, MINN, MINN, 0, 0, 0)); // huge length
        send_beat(make_beat(MAXP, MAXP, MAXP, MAXP, 0, 0, 0));
        send_beat(make_beat(ONE, 0, 0, 0, MAXP, MAXP, MAXP));
        send_beat(make_beat(ONE, 0, 0, 0, MINN, MINN, MINN));
        send_beat(make_beat(MINN, MAXP, MINN, MAXP, MAXP, MINN, MAXP));
        send_beat(make_beat(0, 0, 0, 1, 0, 0, 0));
        send_beat(make_beat(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        drain();
        write_step(32'hFFFF_FFFF);
        send_beat(make_beat(ONE, ONE, ONE, ONE, MAXP, MAXP, MAXP));
        send_beat(make_beat(MAXP, MINN, MAXP, MINN, MINN, MINN, MINN));
        send_beat(make_beat(MINN, MINN, MINN, MINN, MAXP, MINN, MAXP));
        send_beat(make_beat(ONE, 0, 0, 0, 32'h0100_0000, 0, 0));
        send_beat(make_beat(0, ONE, 0, 0, 0, 32'hFF00_0000, 0));
        drain();
        write_step(32'd0);
        send_beat(make_beat(0, 0, 0, 0, MAXP, MAXP, MAXP));
        send_beat(make_beat(ONE, ONE, 0, 0, MINN, 0, 0));
        drain();

        // Random phases over time steps and idle patterns
        steps  = '{qai_pkg::TIME_STEP_RST, 32'hFFFF_FFFF, 32'd0, 32'h0100_0000,
                   32'h0000_0001};
        idle_s = '{0, 50, 0, 36, 0};
        idle_p = '{0, 0, 50, 36, 0};
        for (int ph = 0; ph < 5; ph++) begin
            write_step(ph == 4 ? $urandom() : steps[ph]);
            send_idle_pct = idle_s[ph];
            pop_stall_pct = idle_p[ph];
            for (int n = 0; n < 186; n++) send_beat(random_beat());
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/qai_pkg.sv
sv/qai_front.sv
sv/qai_fifo.sv
sv/qai_back.sv
sv/quaternion_attitude_integrate_unit.sv
verif/testbench.sv
